@@ rtl/c2e_pkg.sv @@
// types, constants and helpers shared by the calendar to epoch seconds block
`default_nettype none
package c2e_pkg;

    localparam int YEAR_SPAN_LIMIT = 10000;
    localparam int BASE_YEAR       = 1900;

    localparam int YEAR_W = 14;
    localparam int DAYS_W = 23;
    localparam int SECS_W = 40;
    localparam int YDAY_W = 9;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(1970);
    localparam logic [YEAR_W-1:0] YEAR_LAST  = YEAR_W'(BASE_YEAR + YEAR_SPAN_LIMIT);

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;

    // epoch day was a thursday
    localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_LIMIT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_MUL,
        S_HMS,
        S_MOD7,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [13:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic [4:0]  cal_hour;
        logic [5:0]  cal_minute;
        logic [5:0]  cal_second;
    } t_cal_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [39:0] epoch_seconds;
        logic [8:0]         day_of_year;
        logic [2:0]         weekday;
    } t_cal_out;

    typedef struct packed {
        logic              start;
        logic [YEAR_W-1:0] year;
    } t_walk_ctl;

    typedef struct packed {
        logic              done;
        logic              leap;
        logic [DAYS_W-1:0] days;
        logic [2:0]        wd;
    } t_walk_sts;

    function automatic logic [YDAY_W-1:0] days_before_month(input logic [3:0] midx);
        logic [YDAY_W-1:0] d;
        case (midx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

@@ rtl/c2e_year_walk.sv @@
// year walker: steps one year a cycle from 1970, summing days and weekday
`default_nettype none
module c2e_year_walk (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire c2e_pkg::t_walk_ctl i_ctl,
    output c2e_pkg::t_walk_sts      o_sts
);
    import c2e_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [YEAR_W-1:0] r_yr, n_yr;
    logic [1:0]        r_y4, n_y4;
    logic [6:0]        r_y100, n_y100;
    logic [8:0]        r_y400, n_y400;
    logic [DAYS_W-1:0] r_days, n_days;
    logic [2:0]        r_wd, n_wd;
    logic              leap;
    logic [3:0]        wd_sum;

    assign leap = (r_y4 == 2'd0) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_yr   = r_yr;
        n_y4   = r_y4;
        n_y100 = r_y100;
        n_y400 = r_y400;
        n_days = r_days;
        n_wd   = r_wd;
        wd_sum = 4'(r_wd) + 4'd1 + 4'(leap);
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_yr   = EPOCH_YEAR;
            n_y4   = 2'd2;
            n_y100 = 7'd70;
            n_y400 = 9'd370;
            n_days = '0;
            n_wd   = EPOCH_WEEKDAY;
        end else if (r_busy) begin
            if (r_yr == i_ctl.year) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_yr   = r_yr + YEAR_W'(1);
                n_y4   = r_y4 + 2'd1;
                n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                n_days = r_days + DAYS_W'(365) + DAYS_W'(leap);
                n_wd   = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_yr   <= n_yr;
        r_y4   <= n_y4;
        r_y100 <= n_y100;
        r_y400 <= n_y400;
        r_days <= n_days;
        r_wd   <= n_wd;
    end

    assign o_sts.done = r_done;
    assign o_sts.leap = leap;
    assign o_sts.days = r_days;
    assign o_sts.wd   = r_wd;

endmodule
`default_nettype wire

@@ rtl/calendar_to_epoch_seconds.sv @@
// calendar date and time to seconds since 1970, with day of year and weekday
//
// One word in, one word out. A word that fails the field checks goes straight
// to S_DONE and is answered from there. Any other word walks the calendar one
// year per clock from 1970 up to the given year, then passes through S_MUL,
// S_HMS and S_MOD7, which reduces the day of year modulo 7 by repeated
// subtraction, before S_DONE. A year past the limit skips the arithmetic after
// the walk. o_ready is low while a word is in work; a finished word waits in
// the output register and does not block the next input word.
`default_nettype none
module calendar_to_epoch_seconds (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire c2e_pkg::t_cal_in  i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output c2e_pkg::t_cal_out      o_data
);
    import c2e_pkg::*;

    t_state            r_state, n_state;
    t_cal_in           r_in, n_in;
    t_status           r_status, n_status;
    logic [YDAY_W-1:0] r_yday, n_yday;
    logic [YDAY_W-1:0] r_rem, n_rem;
    logic [DAYS_W-1:0] r_days, n_days;
    logic [SECS_W-1:0] r_secs, n_secs;
    logic [2:0]        r_wd, n_wd;
    t_cal_out          r_out, n_out;
    logic              r_out_vld, n_out_vld;

    t_walk_ctl         walk_ctl;
    t_walk_sts         walk_sts;
    logic              accept;
    logic              bad_field;
    logic [YDAY_W-1:0] yday;
    logic [3:0]        wd_sum;
    logic [16:0]       hms_secs;

    c2e_year_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (walk_ctl),
        .o_sts   (walk_sts)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign bad_field = (i_data.cal_year < EPOCH_YEAR)
                    || !(i_data.cal_month inside {[4'd1:4'd12]})
                    || (i_data.cal_day == 5'd0)
                    || (i_data.cal_hour > 5'd23)
                    || (i_data.cal_minute > 6'd59)
                    || (i_data.cal_second > 6'd60);

    assign yday = YDAY_W'(r_in.cal_day - 5'd1)
                + days_before_month(r_in.cal_month - 4'd1)
                + YDAY_W'((r_in.cal_month > 4'd2) && walk_sts.leap);

    assign hms_secs = 17'(r_in.cal_hour) * SECS_PER_HOUR
                    + 17'(r_in.cal_minute) * SECS_PER_MIN
                    + 17'(r_in.cal_second);

    assign wd_sum = 4'(walk_sts.wd) + 4'(r_rem[2:0]);

    always_comb begin
        n_state        = r_state;
        n_in           = r_in;
        n_status       = r_status;
        n_yday         = r_yday;
        n_rem          = r_rem;
        n_days         = r_days;
        n_secs         = r_secs;
        n_wd           = r_wd;
        n_out          = r_out;
        n_out_vld      = r_out_vld && !i_ready;
        walk_ctl.start = 1'b0;
        walk_ctl.year  = r_in.cal_year;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_in = i_data;
                    if (bad_field) begin
                        n_status = ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        walk_ctl.start = 1'b1;
                        n_state        = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (walk_sts.done) begin
                    n_yday = yday;
                    n_rem  = yday;
                    n_days = walk_sts.days + DAYS_W'(yday);
                    if (r_in.cal_year > YEAR_LAST) begin
                        n_status = ST_LIMIT;
                        n_state  = S_DONE;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_secs  = SECS_W'(r_days) * SECS_W'(SECS_PER_DAY);
                n_state = S_HMS;
            end
            S_HMS: begin
                n_secs  = r_secs + SECS_W'(hms_secs);
                n_state = S_MOD7;
            end
            S_MOD7: begin
                if (r_rem >= YDAY_W'(7)) begin
                    n_rem = r_rem - YDAY_W'(7);
                end else begin
                    n_wd    = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    n_out.status = r_status;
                    case (r_status)
                        ST_OK: begin
                            n_out.epoch_seconds = signed'(r_secs);
                            n_out.day_of_year   = r_yday;
                            n_out.weekday       = r_wd;
                        end
                        ST_LIMIT: begin
                            n_out.epoch_seconds = '1;
                            n_out.day_of_year   = r_yday;
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_in     <= n_in;
        r_status <= n_status;
        r_yday   <= n_yday;
        r_rem    <= n_rem;
        r_days   <= n_days;
        r_secs   <= n_secs;
        r_wd     <= n_wd;
        r_out    <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("accepted word did not make the block busy");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_RANGE) |->
            (o_data.epoch_seconds == '0 && o_data.day_of_year == '0
             && o_data.weekday == '0))
        else $error("range error word carries nonzero fields");

    a_limit_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_LIMIT) |->
            (o_data.epoch_seconds == '1 && o_data.weekday == '0))
        else $error("limit word has wrong seconds or weekday");

    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_HMS || r_state == S_MOD7) |-> walk_sts.done)
        else $error("arithmetic ran before the year walk finished");

    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.weekday < 3'd7 && o_data.status != 2'd3))
        else $error("weekday or status out of range");

endmodule
`default_nettype wire
